// ----- hdl/rcu_pkg.sv -----
// ----------------------------------------------------------------------------
// rcu_pkg: shared types and codes for the rename checkpoint unit
// operation, operand kind and status codes, field widths and the item structs
// ----------------------------------------------------------------------------
package rcu_pkg;

   localparam int unsigned OpW   = 3;
   localparam int unsigned RegW  = 6;
   localparam int unsigned KindW = 2;
   localparam int unsigned ValW  = 12;
   localparam int unsigned PregW = 5;
   localparam int unsigned PhysW = 5;
   localparam int unsigned StatW = 2;

   // operations
   localparam logic [OpW-1:0] OP_RENAME_DEST = 3'd0;
   localparam logic [OpW-1:0] OP_RENAME      = 3'd1;
   localparam logic [OpW-1:0] OP_BRANCH      = 3'd2;
   localparam logic [OpW-1:0] OP_FLUSH       = 3'd3;
   localparam logic [OpW-1:0] OP_RELEASE     = 3'd4;
   localparam logic [OpW-1:0] OP_COMMIT      = 3'd5;
   localparam logic [OpW-1:0] OP_FREE_SCAN   = 3'd6;

   // source operand kinds on the request side
   localparam logic [KindW-1:0] SRC_UNUSED = 2'd0;
   localparam logic [KindW-1:0] SRC_REG    = 2'd1;
   localparam logic [KindW-1:0] SRC_IMM    = 2'd2;

   // renamed operand kinds on the response side
   localparam logic [KindW-1:0] OUT_UNUSED  = 2'd0;
   localparam logic [KindW-1:0] OUT_PENDING = 2'd1;
   localparam logic [KindW-1:0] OUT_PHYS    = 2'd2;
   localparam logic [KindW-1:0] OUT_IMM     = 2'd3;

   // status codes
   localparam logic [StatW-1:0] ST_OK        = 2'd0;
   localparam logic [StatW-1:0] ST_NO_FREE   = 2'd1;
   localparam logic [StatW-1:0] ST_CKPT_FULL = 2'd2;
   localparam logic [StatW-1:0] ST_NO_CKPT   = 2'd3;

   typedef struct packed {
      logic [OpW-1:0]   opcode;
      logic [RegW-1:0]  dest_reg;
      logic [KindW-1:0] src_a_kind;
      logic [ValW-1:0]  src_a;
      logic [KindW-1:0] src_b_kind;
      logic [ValW-1:0]  src_b;
      logic [KindW-1:0] src_c_kind;
      logic [ValW-1:0]  src_c;
      logic [PhysW-1:0] phys_reg;
   } req_type;

   typedef struct packed {
      logic [StatW-1:0] status;
      logic             dest_written;
      logic [PregW-1:0] dest_preg;
      logic [KindW-1:0] out_a_kind;
      logic [ValW-1:0]  out_a;
      logic [KindW-1:0] out_b_kind;
      logic [ValW-1:0]  out_b;
      logic [KindW-1:0] out_c_kind;
      logic [ValW-1:0]  out_c;
   } rsp_type;

endpackage

// ----- hdl/rcu_src_xlate.sv -----
// ----------------------------------------------------------------------------
// rcu_src_xlate: source operand translation
// looks an architectural register up in the reverse map by associative match
// ----------------------------------------------------------------------------
module rcu_src_xlate #(
   parameter int unsigned PHYS_REGS = 32,
   parameter int unsigned ARCH_REGS = 64
) (
   input  logic [rcu_pkg::KindW-1:0]                      src_kind,
   input  logic [rcu_pkg::ValW-1:0]                       src_val,
   input  logic [PHYS_REGS-1:0][$clog2(ARCH_REGS)-1:0]    rev_map,
   input  logic [PHYS_REGS-1:0]                           live,
   output logic [rcu_pkg::KindW-1:0]                      out_kind,
   output logic [rcu_pkg::ValW-1:0]                       out_val
);

   localparam int unsigned PW = $clog2(PHYS_REGS);
   localparam int unsigned AW = $clog2(ARCH_REGS);
   localparam int unsigned VW = rcu_pkg::ValW;

   logic          in_range;
   logic          hit;
   logic [PW-1:0] hit_idx;

   // at most one live entry carries a given architectural register
   always_comb begin
      in_range = src_val < VW'(ARCH_REGS);
      hit      = 1'b0;
      hit_idx  = '0;
      for (int p = 0; p < PHYS_REGS; p++) begin
         if (live[p] && rev_map[p] == src_val[AW-1:0]) begin
            hit     = 1'b1;
            hit_idx = hit_idx | PW'(p);
         end
      end
   end

   always_comb begin
      out_kind = rcu_pkg::OUT_UNUSED;
      out_val  = '0;
      case (src_kind)
         rcu_pkg::SRC_REG: begin
            if (in_range && hit) begin
               out_kind = rcu_pkg::OUT_PHYS;
               out_val  = VW'(hit_idx);
            end else begin
               out_kind = rcu_pkg::OUT_PENDING;
            end
         end
         rcu_pkg::SRC_IMM: begin
            out_kind = rcu_pkg::OUT_IMM;
            out_val  = src_val;
         end
         default: begin
            out_kind = rcu_pkg::OUT_UNUSED;
         end
      endcase
   end

endmodule

// ----- hdl/rcu_core.sv -----
// ----------------------------------------------------------------------------
// rcu_core: rename state, free list and checkpoint queue
// computes the response of one item and updates the state when it fires
// ----------------------------------------------------------------------------
module rcu_core #(
   parameter int unsigned PHYS_REGS   = 32,
   parameter int unsigned ARCH_REGS   = 64,
   parameter int unsigned CHECKPOINTS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  rcu_pkg::req_type req,
   output rcu_pkg::rsp_type rsp
);

   localparam int unsigned PW   = $clog2(PHYS_REGS);
   localparam int unsigned AW   = $clog2(ARCH_REGS);
   localparam int unsigned HW   = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;
   localparam int unsigned CNTW = $clog2(CHECKPOINTS + 1);
   localparam int unsigned SW   = CNTW + 1;
   localparam int unsigned PRW  = rcu_pkg::PregW;

   // live reverse map: live marks a physical register as the current mapping
   // of the architectural register held in rev_map
   logic [PHYS_REGS-1:0][AW-1:0] rev_ff, rev_in;
   logic [PHYS_REGS-1:0]         rvalid_ff, rvalid_in;
   logic [PHYS_REGS-1:0]         live_ff, live_in;
   logic [PHYS_REGS-1:0]         free_ff, free_in;
   logic [PHYS_REGS-1:0]         commit_ff, commit_in;
   logic [HW-1:0]                head_ff, head_in;
   logic [CNTW-1:0]              count_ff, count_in;

   // checkpoint rows
   logic [CHECKPOINTS-1:0][PHYS_REGS-1:0][AW-1:0] save_rev_ff;
   logic [CHECKPOINTS-1:0][PHYS_REGS-1:0]         save_rvalid_ff;
   logic [CHECKPOINTS-1:0][PHYS_REGS-1:0]         save_live_ff;
   logic [CHECKPOINTS-1:0][PHYS_REGS-1:0]         save_free_ff;

   logic [7:0]           dmod;
   logic [AW-1:0]        dest_arch;
   logic                 has_free;
   logic [PW-1:0]        free_idx;
   logic [PHYS_REGS-1:0] old_map;
   logic [SW-1:0]        slot_sum;
   logic [HW-1:0]        push_slot;
   logic [HW-1:0]        head_next;
   logic                 ckpt_full;
   logic                 ckpt_empty;
   logic                 push_en;
   logic                 commit_ok;
   logic [PW-1:0]        commit_idx;

   logic [rcu_pkg::KindW-1:0] a_kind, b_kind, c_kind;
   logic [rcu_pkg::ValW-1:0]  a_val, b_val, c_val;

   rcu_src_xlate #(.PHYS_REGS(PHYS_REGS), .ARCH_REGS(ARCH_REGS)) u_xlate_a (
      .src_kind (req.src_a_kind),
      .src_val  (req.src_a),
      .rev_map  (rev_ff),
      .live     (live_ff),
      .out_kind (a_kind),
      .out_val  (a_val)
   );

   rcu_src_xlate #(.PHYS_REGS(PHYS_REGS), .ARCH_REGS(ARCH_REGS)) u_xlate_b (
      .src_kind (req.src_b_kind),
      .src_val  (req.src_b),
      .rev_map  (rev_ff),
      .live     (live_ff),
      .out_kind (b_kind),
      .out_val  (b_val)
   );

   rcu_src_xlate #(.PHYS_REGS(PHYS_REGS), .ARCH_REGS(ARCH_REGS)) u_xlate_c (
      .src_kind (req.src_c_kind),
      .src_val  (req.src_c),
      .rev_map  (rev_ff),
      .live     (live_ff),
      .out_kind (c_kind),
      .out_val  (c_val)
   );

   // destination modulo arch register count, subtract and compare
   always_comb begin
      dmod = {2'b00, req.dest_reg};
      for (int i = 0; i < 8; i++) begin
         if (dmod >= 8'(ARCH_REGS)) begin
            dmod = dmod - 8'(ARCH_REGS);
         end
      end
      dest_arch = dmod[AW-1:0];
   end

   // lowest free physical register
   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int p = PHYS_REGS - 1; p >= 0; p--) begin
         if (free_ff[p]) begin
            has_free = 1'b1;
            free_idx = PW'(p);
         end
      end
   end

   // previous mapping of the destination
   always_comb begin
      for (int p = 0; p < PHYS_REGS; p++) begin
         old_map[p] = live_ff[p] && rev_ff[p] == dest_arch;
      end
   end

   always_comb begin
      slot_sum = SW'(head_ff) + SW'(count_ff);
      if (slot_sum >= SW'(CHECKPOINTS)) begin
         slot_sum = slot_sum - SW'(CHECKPOINTS);
      end
      push_slot  = slot_sum[HW-1:0];
      head_next  = (head_ff == HW'(CHECKPOINTS - 1)) ? '0 : head_ff + 1'b1;
      ckpt_full  = count_ff == CNTW'(CHECKPOINTS);
      ckpt_empty = count_ff == '0;
      push_en    = fire && req.opcode == rcu_pkg::OP_BRANCH && !ckpt_full;
      commit_ok  = 7'(req.phys_reg) < 7'(PHYS_REGS);
      commit_idx = PW'(req.phys_reg);
   end

   // next state
   always_comb begin
      rev_in    = rev_ff;
      rvalid_in = rvalid_ff;
      live_in   = live_ff;
      free_in   = free_ff;
      commit_in = commit_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      if (fire) begin
         case (req.opcode)
            rcu_pkg::OP_RENAME_DEST: begin
               if (has_free) begin
                  live_in             = live_ff & ~old_map;
                  live_in[free_idx]   = 1'b1;
                  rev_in[free_idx]    = dest_arch;
                  rvalid_in[free_idx] = 1'b1;
                  free_in[free_idx]   = 1'b0;
                  commit_in[free_idx] = 1'b0;
               end
            end
            rcu_pkg::OP_BRANCH: begin
               if (!ckpt_full) begin
                  count_in = count_ff + 1'b1;
               end
            end
            rcu_pkg::OP_FLUSH: begin
               if (!ckpt_empty) begin
                  rev_in    = save_rev_ff[head_ff];
                  rvalid_in = save_rvalid_ff[head_ff];
                  live_in   = save_live_ff[head_ff];
                  free_in   = save_free_ff[head_ff];
                  head_in   = head_next;
                  count_in  = count_ff - 1'b1;
               end
            end
            rcu_pkg::OP_RELEASE: begin
               if (!ckpt_empty) begin
                  head_in  = head_next;
                  count_in = count_ff - 1'b1;
               end
            end
            rcu_pkg::OP_COMMIT: begin
               if (commit_ok) begin
                  commit_in[commit_idx] = 1'b1;
               end
            end
            rcu_pkg::OP_FREE_SCAN: begin
               for (int p = 0; p < PHYS_REGS; p++) begin
                  if (rvalid_ff[p] && commit_ff[p] && !live_ff[p]) begin
                     rvalid_in[p] = 1'b0;
                     free_in[p]   = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= '0;
         live_ff   <= '0;
         free_ff   <= '1;
         commit_ff <= '0;
         head_ff   <= '0;
         count_ff  <= '0;
      end else begin
         rvalid_ff <= rvalid_in;
         live_ff   <= live_in;
         free_ff   <= free_in;
         commit_ff <= commit_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rev_ff <= rev_in;
   end

   // branch snapshot, taken from the state the branch itself leaves
   always_ff @(posedge clock) begin
      if (push_en) begin
         save_rev_ff[push_slot]    <= rev_ff;
         save_rvalid_ff[push_slot] <= rvalid_ff;
         save_live_ff[push_slot]   <= live_ff;
         save_free_ff[push_slot]   <= free_ff;
      end
   end

   // response
   always_comb begin
      rsp = '0;
      case (req.opcode)
         rcu_pkg::OP_RENAME_DEST: begin
            if (!has_free) begin
               rsp.status = rcu_pkg::ST_NO_FREE;
            end else begin
               rsp.dest_written = 1'b1;
               rsp.dest_preg    = PRW'(free_idx);
               rsp.out_a_kind   = a_kind;
               rsp.out_a        = a_val;
               rsp.out_b_kind   = b_kind;
               rsp.out_b        = b_val;
            end
         end
         rcu_pkg::OP_RENAME, rcu_pkg::OP_BRANCH: begin
            rsp.out_a_kind = a_kind;
            rsp.out_a      = a_val;
            rsp.out_b_kind = b_kind;
            rsp.out_b      = b_val;
            rsp.out_c_kind = c_kind;
            rsp.out_c      = c_val;
            if (req.opcode == rcu_pkg::OP_BRANCH && ckpt_full) begin
               rsp.status = rcu_pkg::ST_CKPT_FULL;
            end
         end
         rcu_pkg::OP_FLUSH, rcu_pkg::OP_RELEASE: begin
            if (ckpt_empty) begin
               rsp.status = rcu_pkg::ST_NO_CKPT;
            end
         end
         default: begin
            rsp.status = rcu_pkg::ST_OK;
         end
      endcase
   end

endmodule

// ----- hdl/register_rename_checkpoint_unit.sv -----
// ----------------------------------------------------------------------------
// register_rename_checkpoint_unit: register renamer with branch checkpoints
// map lookup, free list allocation, checkpoint push/restore and free scan
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the response side stalls, set by the single pass through rcu_core
//    between the request register and the response register
// reset: synchronous; maps read as empty, every physical register free, no
//    checkpoints live; takes effect at once, no clearing pass
module register_rename_checkpoint_unit #(
   parameter int unsigned PHYS_REGS   = 32,
   parameter int unsigned ARCH_REGS   = 64,
   parameter int unsigned CHECKPOINTS = 4
) (
   input  logic        clock,
   input  logic        reset,

   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [5:0]  req_dest_reg,
   input  logic [1:0]  req_src_a_kind,
   input  logic [11:0] req_src_a,
   input  logic [1:0]  req_src_b_kind,
   input  logic [11:0] req_src_b,
   input  logic [1:0]  req_src_c_kind,
   input  logic [11:0] req_src_c,
   input  logic [4:0]  req_phys_reg,

   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_dest_written,
   output logic [4:0]  rsp_dest_preg,
   output logic [1:0]  rsp_out_a_kind,
   output logic [11:0] rsp_out_a,
   output logic [1:0]  rsp_out_b_kind,
   output logic [11:0] rsp_out_b,
   output logic [1:0]  rsp_out_c_kind,
   output logic [11:0] rsp_out_c
);

   // request register stage
   logic             req_valid_ff, req_valid_in;
   rcu_pkg::req_type req_ff, req_in;

   // response register stage
   logic             rsp_valid_ff, rsp_valid_in;
   rcu_pkg::rsp_type rsp_ff, rsp_in;

   rcu_pkg::rsp_type core_rsp;
   logic             fire;
   logic             req_take;

   // the held item moves on whenever the response register is empty or
   // is being drained in the same cycle; the state updates at that edge,
   // so the next item already sees it
   assign fire      = req_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = req_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_in.opcode     = req_opcode;
      req_in.dest_reg   = req_dest_reg;
      req_in.src_a_kind = req_src_a_kind;
      req_in.src_a      = req_src_a;
      req_in.src_b_kind = req_src_b_kind;
      req_in.src_b      = req_src_b;
      req_in.src_c_kind = req_src_c_kind;
      req_in.src_c      = req_src_c;
      req_in.phys_reg   = req_phys_reg;
   end

   // request stage refills whenever it is not held
   always_comb begin
      req_valid_in = req_stall ? req_valid_ff : req_valid;
   end

   // response stage: loads on fire, empties once the item is taken
   always_comb begin
      rsp_in = core_rsp;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   // rename state, free list and checkpoint queue
   rcu_core #(
      .PHYS_REGS   (PHYS_REGS),
      .ARCH_REGS   (ARCH_REGS),
      .CHECKPOINTS (CHECKPOINTS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_ff),
      .rsp   (core_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_dest_written = rsp_ff.dest_written;
   assign rsp_dest_preg    = rsp_ff.dest_preg;
   assign rsp_out_a_kind   = rsp_ff.out_a_kind;
   assign rsp_out_a        = rsp_ff.out_a;
   assign rsp_out_b_kind   = rsp_ff.out_b_kind;
   assign rsp_out_b        = rsp_ff.out_b;
   assign rsp_out_c_kind   = rsp_ff.out_c_kind;
   assign rsp_out_c        = rsp_ff.out_c;

endmodule
